### rtl/erm_pkg.sv
// erm_pkg: shared types and constants of the echo range motion tracker
// no dependencies; imported by erm_div and echo_range_motion_tracker_core
package erm_pkg;

  localparam int DIST_W    = 24;
  localparam int ELAPSED_W = 16;
  localparam int TMO_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 24;
  localparam int DIR_W     = 2;
  localparam int DIV_CNT_W = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // speed of sound, um per us, one way; halved in use for the out-and-back path
  localparam logic [8:0] SOUND_UM_US = 9'd343;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_MAX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 2'd3;

  // register reset values
  localparam logic [TMO_W-1:0]  RST_ECHO_TIMEOUT = 16'd30000;
  localparam logic [DIST_W-1:0] RST_PRESENCE_MIN = 24'd20000;
  localparam logic [DIST_W-1:0] RST_PRESENCE_MAX = 24'd2000000;
  localparam logic [DIST_W-1:0] RST_DEADBAND     = 24'd50;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_UNKNOWN     = 2'd0;
  localparam logic [DIR_W-1:0] DIR_STATIONARY  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_APPROACHING = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RECEDING    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_t;

  // handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic [DIST_W-1:0]    dividend;
    logic [ELAPSED_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIST_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/erm_div.sv
// erm_div: restoring divider, one quotient bit per cycle
// depends on erm_pkg for widths and the request/response structs
module erm_div import erm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIST_W-1:0]    quot;
  logic [ELAPSED_W-1:0] rem;
  logic [ELAPSED_W-1:0] dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [ELAPSED_W:0] trial;
  logic               fits;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, quot[DIST_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIST_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      quot <= {quot[DIST_W-2:0], fits};
      rem  <= fits ? ELAPSED_W'(trial - {1'b0, dsr}) : trial[ELAPSED_W-1:0];
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quot;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(busy))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start)
    else $error("divider restarted while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt < DIV_CNT_W'(DIST_W))
    else $error("divider step count out of range");

endmodule

### rtl/echo_range_motion_tracker_core.sv
// echo_range_motion_tracker_core: ultrasonic echo to distance, presence and radial speed
// each input beat is evaluated, then divided when a speed is computed, then loaded into
// the output register; timeout, no-history and absent readings skip the divider. a new
// beat is taken only once the last is loaded, so a stalled output stalls input; the divider
// gives one quotient bit per cycle. synchronous active-high reset restores register defaults
// and clears history. depends on erm_pkg and erm_div
module echo_range_motion_tracker_core import erm_pkg::*; #(
  parameter int ECHO_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  // measurement beats
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ECHO_WIDTH-1:0] echo_width_us,
  input  logic [ELAPSED_W-1:0]  elapsed_ms,
  // result beats
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_W-1:0]     distance_um,
  output logic                  present,
  output logic [DIST_W-1:0]     speed_mm_s,
  output logic [DIR_W-1:0]      direction
);

  // product of width and 343, and common widths for the saturation and timeout compares
  localparam int PROD_W = ECHO_WIDTH + 9;
  localparam int CMP_W  = (PROD_W > DIST_W) ? PROD_W : DIST_W;
  localparam int TCMP_W = (ECHO_WIDTH > TMO_W) ? ECHO_WIDTH : TMO_W;

  // configuration registers
  logic [TMO_W-1:0]  echo_timeout_us;
  logic [DIST_W-1:0] presence_min_um;
  logic [DIST_W-1:0] presence_max_um;
  logic [DIST_W-1:0] deadband_mm_s;

  // history
  logic [DIST_W-1:0] last_distance;

  // captured input beat
  logic [ECHO_WIDTH-1:0] width_q;
  logic [ELAPSED_W-1:0]  elapsed_q;

  // result being built
  logic [DIST_W-1:0] res_dist;
  logic              res_pres;
  logic [DIST_W-1:0] res_speed;
  logic [DIR_W-1:0]  res_dir;
  logic              closer;

  state_t state, state_next;
  logic   out_load;
  logic   div_start;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // config port always takes a write; the block is idle by contract when it happens
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_timeout_us <= RST_ECHO_TIMEOUT;
      presence_min_um <= RST_PRESENCE_MIN;
      presence_max_um <= RST_PRESENCE_MAX;
      deadband_mm_s   <= RST_DEADBAND;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ECHO_TIMEOUT: echo_timeout_us <= cfg_data[TMO_W-1:0];
        REG_PRESENCE_MIN: presence_min_um <= cfg_data;
        REG_PRESENCE_MAX: presence_max_um <= cfg_data;
        REG_DEADBAND:     deadband_mm_s   <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // evaluation of the captured beat (used in the calc state)
  // ---------------------------------------------------------------------------
  logic                  timeout;
  logic [PROD_W-1:0]     prod;
  logic [CMP_W-1:0]      dist_wide;
  logic [DIST_W-1:0]     new_dist;
  logic                  pres;
  logic                  no_speed;
  logic [DIST_W-1:0]     delta;
  logic [ELAPSED_W-1:0]  divisor;

  // zero width or above the timeout register means no echo
  assign timeout = (width_q == '0) ||
                   (TCMP_W'(width_q) > TCMP_W'(echo_timeout_us));

  // distance in um = width * 343 / 2, saturated to 24 bits
  assign prod      = PROD_W'(width_q) * PROD_W'(SOUND_UM_US);
  assign dist_wide = CMP_W'(prod >> 1);
  assign new_dist  = (dist_wide > CMP_W'(DIST_MAX)) ? DIST_MAX : dist_wide[DIST_W-1:0];

  // inverted window never matches
  assign pres = (new_dist >= presence_min_um) && (new_dist <= presence_max_um);

  // no earlier reading or object out of window: skip the division
  assign no_speed = (last_distance == '0) || !pres;

  assign delta   = (new_dist >= last_distance) ? (new_dist - last_distance)
                                               : (last_distance - new_dist);
  assign divisor = (elapsed_q == '0) ? ELAPSED_W'(1) : elapsed_q;

  assign div_req.start    = div_start;
  assign div_req.dividend = delta;
  assign div_req.divisor  = divisor;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (timeout || no_speed) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        // output register frees up, or is freed this cycle
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // capture the beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      width_q   <= echo_width_us;
      elapsed_q <= elapsed_ms;
    end
  end

  // history only moves on a real echo
  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
    end else if (state == ST_CALC && !timeout) begin
      last_distance <= new_dist;
    end
  end

  // result scratch
  always_ff @(posedge clk) begin
    if (state == ST_CALC) begin
      closer <= new_dist < last_distance;
      if (timeout) begin
        res_dist  <= last_distance;
        res_pres  <= 1'b0;
        res_speed <= '0;
        res_dir   <= DIR_UNKNOWN;
      end else begin
        res_dist  <= new_dist;
        res_pres  <= pres;
        res_speed <= '0;
        res_dir   <= pres ? DIR_STATIONARY : DIR_UNKNOWN;
      end
    end else if (state == ST_DIV && div_rsp.done) begin
      // quotient of a 24-bit delta never exceeds 24 bits
      res_speed <= div_rsp.quotient;
      if (div_rsp.quotient < deadband_mm_s) begin
        res_dir <= DIR_STATIONARY;
      end else if (closer) begin
        res_dir <= DIR_APPROACHING;
      end else begin
        res_dir <= DIR_RECEDING;
      end
    end
  end

  // speed divider
  erm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // output register, holds a finished beat while the next one is taken in
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      distance_um <= res_dist;
      present     <= res_pres;
      speed_mm_s  <= res_speed;
      direction   <= res_dir;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CALC))
    else $error("accepted beat did not enter evaluation");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_div_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == ST_DIV))
    else $error("divider running outside the divide state");

  a_unknown_is_still: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction == DIR_UNKNOWN) |-> (speed_mm_s == '0 && !present))
    else $error("unknown direction with speed or presence");

  a_moving_is_present: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction != DIR_UNKNOWN) |-> present)
    else $error("known direction without presence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(distance_um) && $stable(direction))
    else $error("pending result overwritten");

endmodule

### bench/echo_range_motion_tracker_core_test.sv
`timescale 1ns / 1ps
// echo_range_motion_tracker_core_test: self-checking bench for the echo range motion tracker
// depends on erm_pkg and echo_range_motion_tracker_core, which in turn needs erm_div
module echo_range_motion_tracker_core_test;
  import erm_pkg::*;

  localparam int ECHO_W        = 16;
  localparam int HALF_PERIOD   = 5;
  localparam int SETTLE_CYCLES = 40;          // margin for the block to go quiet after the last reading
  localparam int TIMEOUT_NS    = 10_000_000;  // well over ten times the slowest expected run

  // one measurement beat as queued for the driver
  typedef struct {
    logic [ECHO_W-1:0]    width;
    logic [ELAPSED_W-1:0] elapsed;
  } echo_beat_t;

  // one result beat, as predicted or as seen on the outputs
  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              present;
    logic [DIST_W-1:0] speed;
    logic [DIR_W-1:0]  direction;
  } reading_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ECHO_TIMEOUT;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ECHO_W-1:0]    echo_width_us = '0;
  logic [ELAPSED_W-1:0] elapsed_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DIST_W-1:0]    distance_um;
  logic                 present;
  logic [DIST_W-1:0]    speed_mm_s;
  logic [DIR_W-1:0]     direction;

  // bench copy of the register file and of the stored distance
  logic [TMO_W-1:0]  timeout_us    = RST_ECHO_TIMEOUT;
  logic [DIST_W-1:0] win_min_um    = RST_PRESENCE_MIN;
  logic [DIST_W-1:0] win_max_um    = RST_PRESENCE_MAX;
  logic [DIST_W-1:0] deadband_mm_s = RST_DEADBAND;
  logic [DIST_W-1:0] last_dist_um  = '0;

  echo_beat_t pending_echoes[$];
  reading_t   expected_readings[$];
  int         outstanding    = 0;  // beats queued whose reading has not come back yet
  int         errors         = 0;
  int         send_gap_pct   = 0;
  int         recv_stall_pct = 0;

  echo_range_motion_tracker_core #(
    .ECHO_WIDTH(ECHO_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .echo_width_us(echo_width_us),
    .elapsed_ms   (elapsed_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .distance_um  (distance_um),
    .present      (present),
    .speed_mm_s   (speed_mm_s),
    .direction    (direction)
  );

  always #HALF_PERIOD clk = ~clk;

  // expected reading for one accepted beat; updates the stored distance as the block does
  function automatic reading_t track_reading(input logic [ECHO_W-1:0] width,
                                             input logic [ELAPSED_W-1:0] elapsed);
    reading_t             r;
    logic [63:0]          flight_um;
    logic [DIST_W-1:0]    prev;
    logic [DIST_W-1:0]    new_dist;
    logic [DIST_W-1:0]    delta;
    logic [ELAPSED_W-1:0] divisor;
    logic                 in_window;
    prev        = last_dist_um;
    r.distance  = prev;
    r.present   = 1'b0;
    r.speed     = '0;
    r.direction = DIR_UNKNOWN;
    // no echo: report the held distance and leave it alone
    if (width == 0 || width > timeout_us) return r;
    // out and back, so half of width times the speed of sound
    flight_um    = (64'(width) * 64'(SOUND_UM_US)) >> 1;
    new_dist     = (flight_um > 64'(DIST_MAX)) ? DIST_MAX : flight_um[DIST_W-1:0];
    last_dist_um = new_dist;
    in_window    = (new_dist >= win_min_um) && (new_dist <= win_max_um);
    r.distance   = new_dist;
    r.present    = in_window;
    // first reading or out of the window: no speed
    if (prev == 0 || !in_window) begin
      r.direction = in_window ? DIR_STATIONARY : DIR_UNKNOWN;
      return r;
    end
    delta   = (new_dist >= prev) ? new_dist - prev : prev - new_dist;
    divisor = (elapsed == 0) ? ELAPSED_W'(1) : elapsed;
    // um per ms is mm per s; a 24-bit delta over a 16-bit divisor cannot exceed 24 bits
    r.speed = delta / divisor;
    if (r.speed < deadband_mm_s) r.direction = DIR_STATIONARY;
    else if (new_dist < prev)    r.direction = DIR_APPROACHING;
    else                         r.direction = DIR_RECEDING;
    return r;
  endfunction

  // driver: predicts on every accepted beat, then offers the next queued one
  always @(posedge clk) begin : drive_echoes
    echo_beat_t next_echo;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(track_reading(echo_width_us, elapsed_ms));
      end
      // slot is free once the current beat has gone, or if none was offered
      if (!in_valid || in_ready) begin
        if (pending_echoes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_echo     = pending_echoes.pop_front();
          in_valid      <= 1'b1;
          echo_width_us <= next_echo.width;
          elapsed_ms    <= next_echo.elapsed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: every result beat is matched against the oldest prediction
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading: distance_um %0d present %0d speed_mm_s %0d dir %0d",
                   $time, distance_um, present, speed_mm_s, direction);
          errors++;
        end else begin
          want = expected_readings.pop_front();
          outstanding--;
          if (distance_um !== want.distance) begin
            $display("%0t: distance_um expected %0d, got %0d", $time, want.distance, distance_um);
            errors++;
          end
          if (present !== want.present) begin
            $display("%0t: present expected %0d, got %0d", $time, want.present, present);
            errors++;
          end
          if (speed_mm_s !== want.speed) begin
            $display("%0t: speed_mm_s expected %0d, got %0d", $time, want.speed, speed_mm_s);
            errors++;
          end
          if (direction !== want.direction) begin
            $display("%0t: direction expected %0d, got %0d", $time, want.direction, direction);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic add_echo(input logic [ECHO_W-1:0] width, input logic [ELAPSED_W-1:0] elapsed);
    echo_beat_t b;
    b.width   = width;
    b.elapsed = elapsed;
    pending_echoes.push_back(b);
    outstanding++;
  endtask

  // wait until every queued beat has produced its reading, then let the block go quiet
  task automatic settle();
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register write beat; the bench copy follows once the beat is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ECHO_TIMEOUT: timeout_us    = val[TMO_W-1:0];
      REG_PRESENCE_MIN: win_min_um    = val;
      REG_PRESENCE_MAX: win_max_um    = val;
      REG_DEADBAND:     deadband_mm_s = val;
      default: ;
    endcase
  endtask

  // registers only change with the block idle
  task automatic set_regs(input logic [TMO_W-1:0] tmo, input logic [DIST_W-1:0] lo,
                          input logic [DIST_W-1:0] hi, input logic [DIST_W-1:0] db);
    settle();
    write_reg(REG_ECHO_TIMEOUT, CFG_DAT_W'(tmo));
    write_reg(REG_PRESENCE_MIN, lo);
    write_reg(REG_PRESENCE_MAX, hi);
    write_reg(REG_DEADBAND, db);
  endtask

  // mostly a target wandering inside the window, so the speed path is busy,
  // with missing echoes, over-long echoes, jumps and arbitrary widths mixed in
  task automatic queue_track(input int count);
    int tmo;
    int lo_w;
    int hi_w;
    int track_w;
    int w;
    int e;
    tmo  = int'(timeout_us);
    lo_w = (int'(win_min_um) * 2 + 342) / 343;
    hi_w = (int'(win_max_um) * 2 + 1) / 343;
    if (lo_w < 1) lo_w = 1;
    if (hi_w > tmo) hi_w = tmo;
    if (lo_w > hi_w) begin
      lo_w = 1;
      hi_w = tmo;
    end
    track_w = $urandom_range(hi_w, lo_w);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(19))
        0: w = 0;
        1: w = (tmo < 65535) ? int'($urandom_range(65535, tmo + 1)) : 0;
        2: w = $urandom_range(65535);
        3: begin
          track_w = $urandom_range(hi_w, lo_w);
          w = track_w;
        end
        4, 5: w = track_w;  // target standing still
        default: begin
          track_w = track_w + int'($urandom_range(400)) - 200;
          if (track_w < lo_w) track_w = lo_w;
          if (track_w > hi_w) track_w = hi_w;
          w = track_w;
        end
      endcase
      case ($urandom_range(9))
        0: e = 0;
        1: e = $urandom_range(65535);
        default: e = $urandom_range(300, 1);
      endcase
      add_echo(ECHO_W'(w), ELAPSED_W'(e));
    end
  endtask

  initial begin : run_phases
    int rand_lo;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // light sender gaps, heavy receiver back-pressure
    send_gap_pct   = 10;
    recv_stall_pct = 59;

    // directed part, reset register values
    add_echo(0, 0);                 // missing echo before any history
    add_echo(100, 5);               // below the window, still stored
    add_echo(117, 10);              // first speed, slowly receding
    add_echo(30000, 20);            // width equal to the timeout is a real echo, beyond window
    add_echo(30001, 20);            // just over the timeout
    add_echo(16'hFFFF, 16'hFFFF);   // widest width, no echo
    add_echo(1000, 0);              // zero elapsed time taken as one, fast approach
    add_echo(1000, 16'hFFFF);       // same distance, stationary
    add_echo(1100, 1);              // receding
    add_echo(1050, 16'hFFFF);       // speed rounds down to nothing

    // zero deadband: equal distances count as receding; full window, longest timeout
    set_regs(16'hFFFF, '0, DIST_MAX, '0);
    add_echo(1050, 7);
    add_echo(16'hFFFF, 1);          // furthest reachable distance
    add_echo(1, 1);                 // nearest distance, huge approach speed

    // inverted window: nothing is present
    set_regs(16'hFFFF, 24'd5000000, 24'd100, DIST_MAX);
    add_echo(1000, 3);

    // single-point window, widest deadband
    set_regs(16'hFFFF, 24'd34300, 24'd34300, DIST_MAX);
    add_echo(200, 2);               // exactly on the window
    add_echo(201, 2);               // just past it

    // zero timeout register: every width is a timeout
    set_regs('0, RST_PRESENCE_MIN, RST_PRESENCE_MAX, RST_DEADBAND);
    add_echo(1, 9);
    add_echo(16'hFFFF, 9);

    // random part
    set_regs(RST_ECHO_TIMEOUT, RST_PRESENCE_MIN, RST_PRESENCE_MAX, RST_DEADBAND);
    queue_track(170);
    set_regs(16'hFFFF, '0, DIST_MAX, '0);
    queue_track(170);

    settle();
    send_gap_pct   = 59;
    recv_stall_pct = 10;
    rand_lo = $urandom_range(500000);
    set_regs(TMO_W'($urandom_range(65535, 2000)), DIST_W'(rand_lo),
             DIST_W'($urandom_range(8000000, rand_lo)), DIST_W'($urandom_range(3000)));
    queue_track(170);
    set_regs(16'd1, '0, DIST_MAX, DIST_MAX);  // only the shortest echo gets through
    queue_track(40);

    // back to back, no idling on either side
    settle();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    set_regs(16'd40000, 24'd100000, 24'd3000000, 24'd1000);
    queue_track(180);
    rand_lo = $urandom_range(500000);
    set_regs(TMO_W'($urandom_range(65535, 2000)), DIST_W'(rand_lo),
             DIST_W'($urandom_range(8000000, rand_lo)), DIST_W'($urandom_range(3000)));
    queue_track(200);

    settle();
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog in case a handshake never completes
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: timed out with %0d readings outstanding", $time, outstanding);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
